FILE: src/gbe_pkg.sv
// Shared constants, types and state encodings of the group bit encoder.
package gbe_pkg;

    // pixels per group and derived widths
    localparam int GROUP  = 4;
    localparam int FILL_W = $clog2(GROUP);
    localparam int CNT_W  = $clog2(GROUP + 1);
    localparam int IDX_W  = $clog2(GROUP);

    // pixel values with a short code
    localparam logic [7:0] WHITE_PIX = 8'hFF;
    localparam logic [7:0] BLACK_PIX = 8'h00;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_WHITE,
        CMD_BLACK,
        CMD_RAW
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                kind;
        logic [CNT_W-1:0]         count;
        logic                     last;
        logic [GROUP-1:0][7:0]    bytes;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        ST_PREFIX,
        ST_BYTES,
        ST_FLUSH
    } t_back_state;

endpackage

FILE: src/gbe_front.sv
// Front part: collects pixels into groups and classifies each closed group.
module gbe_front
    import gbe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_pixel,
    input  logic             i_final_pixel,
    input  t_q_status        i_q_status,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [7:0]        r_held [GROUP-1];

    logic                  w_accept;
    logic                  w_full_group;
    logic                  w_closing;
    logic                  w_all_white;
    logic                  w_all_black;
    logic [GROUP-1:0][7:0] w_bytes;

    // take a request whenever the queue has room
    assign o_stall      = i_q_status.full;
    assign w_accept     = i_valid && !i_q_status.full;
    assign w_full_group = (r_fill == FILL_W'(GROUP - 1));
    assign w_closing    = w_full_group || i_final_pixel;
    assign o_push       = w_accept && w_closing;

    // gather group bytes and test for uniform white or black
    always_comb begin
        w_all_white = (i_pixel == WHITE_PIX);
        w_all_black = (i_pixel == BLACK_PIX);
        for (int i = 0; i < GROUP - 1; i++) begin
            w_all_white = w_all_white && (r_held[i] == WHITE_PIX);
            w_all_black = w_all_black && (r_held[i] == BLACK_PIX);
            w_bytes[i]  = (FILL_W'(i) < r_fill) ? r_held[i] : i_pixel;
        end
        w_bytes[GROUP-1] = i_pixel;
    end

    // build the command for a closed group
    always_comb begin
        o_cmd.bytes = w_bytes;
        o_cmd.last  = i_final_pixel;
        if (w_full_group) begin
            o_cmd.count = CNT_W'(GROUP);
            if (w_all_white) begin
                o_cmd.kind = CMD_WHITE;
            end else if (w_all_black) begin
                o_cmd.kind = CMD_BLACK;
            end else begin
                o_cmd.kind = CMD_RAW;
            end
        end else begin
            // short tail group always goes raw
            o_cmd.count = CNT_W'(r_fill) + CNT_W'(1);
            o_cmd.kind  = CMD_RAW;
        end
    end

    // advance or restart the group position
    always_comb begin
        n_fill = r_fill;
        if (w_accept) begin
            n_fill = w_closing ? '0 : r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // hold pixels of the open group
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < GROUP - 1; i++) begin
            if (w_accept && !w_closing && (r_fill == FILL_W'(i))) begin
                r_held[i] <= i_pixel;
            end
        end
    end

endmodule

FILE: src/gbe_cmd_fifo.sv
// Short command queue that decouples the group classifier from the bit packer.
module gbe_cmd_fifo
    import gbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_status.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd];

    // store a new command at the tail
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: src/gbe_back.sv
// Back part: packs code bits of each command into bytes and drives the output.
module gbe_back
    import gbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [7:0]  o_code_byte,
    output logic        o_stream_end
);

    t_back_state      r_state;
    t_back_state      n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [6:0]       r_buf;
    logic [6:0]       n_buf;
    logic [2:0]       r_fill;
    logic [2:0]       n_fill;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [7:0]       r_code_byte;
    logic [7:0]       n_code_byte;
    logic             r_stream_end;
    logic             n_stream_end;

    logic        w_advance;
    logic        w_go;
    logic [1:0]  w_pre_bits;
    logic [1:0]  w_pre_len;
    logic [8:0]  w_pre;
    logic [3:0]  w_pre_fill;
    logic [7:0]  w_byte;
    logic [14:0] w_raw;
    logic        w_last_byte;

    assign o_valid      = r_out_valid;
    assign o_code_byte  = r_code_byte;
    assign o_stream_end = r_stream_end;

    // step only when the output slot is free or being taken
    assign w_advance = !r_out_valid || !i_stall;
    assign w_go      = w_advance && !i_q_status.empty;

    // prefix code of the head command, first bit in bit 0
    always_comb begin
        case (i_head.kind)
            CMD_WHITE: begin
                w_pre_bits = 2'b00;
                w_pre_len  = 2'd1;
            end
            CMD_BLACK: begin
                w_pre_bits = 2'b01;
                w_pre_len  = 2'd2;
            end
            default: begin
                w_pre_bits = 2'b11;
                w_pre_len  = 2'd2;
            end
        endcase
    end

    assign w_pre       = {2'b00, r_buf} | ({7'b0, w_pre_bits} << r_fill);
    assign w_pre_fill  = {1'b0, r_fill} + {2'b00, w_pre_len};
    assign w_byte      = i_head.bytes[r_idx];
    assign w_raw       = {8'b0, r_buf} | ({7'b0, w_byte} << r_fill);
    assign w_last_byte = ((CNT_W'(r_idx) + CNT_W'(1)) == i_head.count);

    // sequence prefix, raw bytes and flush of one command
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_buf        = r_buf;
        n_fill       = r_fill;
        n_out_valid  = r_out_valid;
        n_code_byte  = r_code_byte;
        n_stream_end = r_stream_end;
        o_pop        = 1'b0;
        if (w_advance) begin
            n_out_valid = 1'b0;
        end
        if (w_go) begin
            case (r_state)
                ST_PREFIX: begin
                    if (w_pre_fill >= 4'd8) begin
                        n_out_valid  = 1'b1;
                        n_code_byte  = w_pre[7:0];
                        n_stream_end = 1'b0;
                        n_buf        = {6'b0, w_pre[8]};
                        n_fill       = 3'(w_pre_fill - 4'd8);
                    end else begin
                        n_buf  = w_pre[6:0];
                        n_fill = w_pre_fill[2:0];
                    end
                    if (i_head.kind == CMD_RAW) begin
                        n_state = ST_BYTES;
                        n_idx   = '0;
                    end else if (i_head.last) begin
                        n_state = ST_FLUSH;
                    end else begin
                        o_pop = 1'b1;
                    end
                end
                ST_BYTES: begin
                    n_out_valid  = 1'b1;
                    n_code_byte  = w_raw[7:0];
                    n_stream_end = 1'b0;
                    n_buf        = w_raw[14:8];
                    if (w_last_byte) begin
                        if (i_head.last) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_state = ST_PREFIX;
                            o_pop   = 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                ST_FLUSH: begin
                    n_out_valid  = 1'b1;
                    n_code_byte  = {1'b0, r_buf};
                    n_stream_end = 1'b1;
                    n_buf        = '0;
                    n_fill       = '0;
                    n_state      = ST_PREFIX;
                    o_pop        = 1'b1;
                end
                default: begin
                    n_state = ST_PREFIX;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_PREFIX;
            r_idx       <= '0;
            r_buf       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_buf       <= n_buf;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload needs no reset
    always_ff @(posedge i_clk) begin
        r_code_byte  <= n_code_byte;
        r_stream_end <= n_stream_end;
    end

endmodule

FILE: src/grayscale_group_bit_encoder_core.sv
// Top level of the grayscale group bit encoder: front, command queue and back.
// A closing pixel's command is registered in the command queue before the packer reads it; a raw
// group's first code byte passes the prefix and byte states, a shortcut's byte only the prefix state.
// Throughput: one pixel per cycle while the two-entry command queue has room.
// The bit packer handles a prefix, each raw byte and the flush in separate steps, so a raw
// group of four takes a prefix step and a step per byte, a white or black group only its prefix step.
// Reset is synchronous, active low; it clears counters, bit buffer, queue and output valid.
module grayscale_group_bit_encoder_core
    import gbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_pixel,
    input  logic       i_final_pixel,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_code_byte,
    output logic       o_stream_end
);

    t_cmd      w_push_cmd;
    t_cmd      w_head;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    gbe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .i_final_pixel (i_final_pixel),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    gbe_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    gbe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_code_byte  (o_code_byte),
        .o_stream_end (o_stream_end)
    );

endmodule

FILE: src/gbe_checker.sv
// Port-level checks of the group bit encoder, bound to its top level.
module gbe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_code_byte,
    input logic       o_stream_end
);

    // reset empties the output register
    a_reset_out : assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // reset empties the queue, so input is not stalled
    a_reset_in : assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    // hold a stalled result
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code_byte) && $stable(o_stream_end))
        else $error("stalled result changed");

    // flushed byte carries at most seven code bits
    a_flush_pad : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stream_end |-> !o_code_byte[7])
        else $error("flushed byte has top bit set");

endmodule

bind grayscale_group_bit_encoder_core gbe_checker u_gbe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_code_byte  (o_code_byte),
    .o_stream_end (o_stream_end)
);

FILE: dv/tb_grayscale_group_bit_encoder_core.sv
// Self-checking testbench for the grayscale group bit encoder core.
module tb_grayscale_group_bit_encoder_core;
    import gbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_PIXELS  = 330;

    typedef struct {
        logic [7:0] code_byte;
        logic       stream_end;
    } t_code_out;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_pixel       = 8'h00;
    logic       i_final_pixel = 1'b0;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_code_byte;
    logic       o_stream_end;

    // encoder state mirrored by the predictor
    logic [7:0] open_group [GROUP];
    int         open_fill;
    logic [7:0] bit_acc;
    int         bit_cnt;
    t_code_out  code_q [$];

    int fail_cnt     = 0;
    int pixel_cnt    = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    int stall_run    = 0;
    int stall_pct    = 0;

    grayscale_group_bit_encoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .i_final_pixel (i_final_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_byte   (o_code_byte),
        .o_stream_end  (o_stream_end)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_encoder();
        for (int i = 0; i < GROUP; i++) begin
            open_group[i] = 8'h00;
        end
        open_fill = 0;
        bit_acc   = 8'h00;
        bit_cnt   = 0;
    endfunction

    // append one code bit, emit the byte once eight are packed
    function automatic void pack_bit(logic b);
        t_code_out r;
        bit_acc[bit_cnt] = b;
        bit_cnt++;
        if (bit_cnt == 8) begin
            r.code_byte  = bit_acc;
            r.stream_end = 1'b0;
            code_q = {code_q, r};
            bit_acc = 8'h00;
            bit_cnt = 0;
        end
    endfunction

    function automatic void pack_raw_group(int n);
        pack_bit(1'b1);
        pack_bit(1'b1);
        for (int i = 0; i < n; i++) begin
            for (int b = 0; b < 8; b++) begin
                pack_bit(open_group[i][b]);
            end
        end
    endfunction

    function automatic void encode_pixel(logic [7:0] pix, logic fin);
        t_code_out r;
        logic      uniform;
        open_group[open_fill] = pix;
        open_fill++;
        if (open_fill == GROUP) begin
            uniform = 1'b1;
            for (int i = 1; i < GROUP; i++) begin
                if (open_group[i] != open_group[0]) uniform = 1'b0;
            end
            if (uniform && open_group[0] == WHITE_PIX) begin
                pack_bit(1'b0);
            end else if (uniform && open_group[0] == BLACK_PIX) begin
                pack_bit(1'b1);
                pack_bit(1'b0);
            end else begin
                pack_raw_group(GROUP);
            end
            open_fill = 0;
        end else if (fin) begin
            // short tail group never takes a shortcut
            pack_raw_group(open_fill);
            open_fill = 0;
        end
        if (fin) begin
            r.code_byte  = bit_acc;
            r.stream_end = 1'b1;
            code_q = {code_q, r};
            clear_encoder();
        end
    endfunction

    // ---------------------------------------------------------------- monitor

    // predict on each accepted request, then check each accepted code byte
    always @(posedge i_clk) begin : monitor
        t_code_out want;
        if (i_rst_n) begin
            if (i_valid && o_stall === 1'b0) begin
                encode_pixel(i_pixel, i_final_pixel);
            end
            if (o_valid === 1'b1 && !i_stall) begin
                if (code_q.size() == 0) begin
                    $error("code byte %02h with nothing expected", o_code_byte);
                    fail_cnt++;
                end else begin
                    want = code_q.pop_front();
                    if (o_code_byte !== want.code_byte) begin
                        $error("code_byte: expected %02h, actual %02h",
                               want.code_byte, o_code_byte);
                        fail_cnt++;
                    end
                    if (o_stream_end !== want.stream_end) begin
                        $error("stream_end: expected %0b, actual %0b",
                               want.stream_end, o_stream_end);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("grayscale_group_bit_encoder_core verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- receiver

    // hold off when asked, otherwise stall in runs of random density
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            if (stall_run == 0) begin
                stall_run = $urandom_range(4, 40);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    default: stall_pct = 70;
                endcase
            end
            stall_run--;
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------- sender

    // offer one request, with a random gap at the start of each burst
    task automatic send_pixel(input logic [7:0] pix, input logic fin);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(0, 6);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel       <= pix;
        i_final_pixel <= fin;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        burst_left--;
        pixel_cnt++;
    endtask

    task automatic sender_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // wait for every expected byte, then let the block settle
    task automatic wait_results();
        sender_idle();
        while (code_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // send one full group of the given kind; near spoils one pixel
    task automatic send_group(input t_cmd_kind kind, input bit near, input logic fin);
        logic [7:0] px [GROUP];
        int         spot;
        for (int i = 0; i < GROUP; i++) begin
            case (kind)
                CMD_WHITE: px[i] = WHITE_PIX;
                CMD_BLACK: px[i] = BLACK_PIX;
                default:   px[i] = 8'($urandom_range(0, 255));
            endcase
        end
        if (near) begin
            spot     = $urandom_range(0, GROUP - 1);
            px[spot] = px[spot] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < GROUP; i++) begin
            send_pixel(px[i], fin && i == GROUP - 1);
        end
    endtask

    function automatic t_cmd_kind pick_kind();
        case ($urandom_range(0, 9))
            0, 1, 2: return CMD_WHITE;
            3, 4:    return CMD_BLACK;
            default: return CMD_RAW;
        endcase
    endfunction

    // image of whole groups and an optional short tail, final on the last pixel
    task automatic send_image(input int groups, input int tail);
        for (int g = 0; g < groups; g++) begin
            send_group(pick_kind(), $urandom_range(0, 7) == 0, tail == 0 && g == groups - 1);
        end
        for (int i = 0; i < tail; i++) begin
            send_pixel(8'($urandom_range(0, 255)), i == tail - 1);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // shortcuts, near misses, short tails and a flush on a byte boundary
    task automatic test_directed();
        // three black groups make six bits, a one-pixel tail then fills two bytes
        repeat (3) send_group(CMD_BLACK, 1'b0, 1'b0);
        send_pixel(8'h80, 1'b1);
        // white group, near-white raw group, all-black tail of two coded raw
        send_group(CMD_WHITE, 1'b0, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFE, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b1);
        // final pixel closing a white group keeps the shortcut
        send_group(CMD_WHITE, 1'b0, 1'b1);
        // near-black raw group closed by the final pixel
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'h01, 1'b1);
        wait_results();
    endtask

    // random images, mostly well formed, with stray final marks as noise
    task automatic test_random_images();
        int stop_at;
        int groups;
        int tail;
        stop_at = pixel_cnt + RANDOM_PIXELS;
        while (pixel_cnt < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
            end else begin
                groups = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                     : $urandom_range(0, 6);
                tail   = $urandom_range(0, GROUP - 1);
                if (groups == 0 && tail == 0) tail = 1;
                send_image(groups, tail);
            end
        end
        wait_results();
    endtask

    // long receiver hold-off while raw groups keep coming, so the input stalls
    task automatic test_backpressure();
        @(posedge i_clk);
        hold_left = 300;
        for (int g = 0; g < 9; g++) begin
            send_group(CMD_RAW, 1'b0, 1'b0);
        end
        send_image(0, 3);
        wait_results();
    endtask

    // pause mid-image until every byte is out, then finish the image
    task automatic test_pause_mid_image();
        send_group(CMD_RAW, 1'b0, 1'b0);
        send_group(CMD_BLACK, 1'b0, 1'b0);
        send_pixel(8'h5A, 1'b0);
        wait_results();
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_image(2, 2);
        wait_results();
    endtask

    initial begin
        clear_encoder();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_images();
        test_backpressure();
        test_pause_mid_image();

        if (fail_cnt == 0 && code_q.size() == 0) begin
            $display("grayscale_group_bit_encoder_core verification clean");
        end else begin
            $display("grayscale_group_bit_encoder_core verification failed");
        end
        $finish;
    end

endmodule
